>>> src/exyz_pkg.sv
// ---------------------------------------------------------------------------
// exyz_pkg
// Shared constants, tables and helpers for the Euler xyz rotation matrix.
// ---------------------------------------------------------------------------
`default_nettype none
package exyz_pkg;
  localparam int ANGLE_BITS_DEF   = 16;
  localparam int ELEM_FRAC_DEF    = 14;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int IO_W             = 16;
  // Q30 working width: values reach about +-4 rad and +-1.6 unit, 34 bits is ample
  localparam int QW               = 34;

  localparam logic signed [QW-1:0] Q30_ONE_OVER_K = 34'sd652032874;
  localparam logic signed [QW-1:0] Q30_PI         = 34'sd3373259426;
  localparam logic signed [QW-1:0] Q30_HALF_PI    = 34'sd1686629713;

  typedef logic signed [QW-1:0] q30_t;

  function automatic q30_t atan_q30(input int k);
    case (k)
      0:  atan_q30 = 34'sd843314856;
      1:  atan_q30 = 34'sd497837829;
      2:  atan_q30 = 34'sd263043836;
      3:  atan_q30 = 34'sd133525158;
      4:  atan_q30 = 34'sd67021686;
      5:  atan_q30 = 34'sd33543515;
      6:  atan_q30 = 34'sd16775850;
      7:  atan_q30 = 34'sd8388437;
      8:  atan_q30 = 34'sd4194282;
      9:  atan_q30 = 34'sd2097149;
      10: atan_q30 = 34'sd1048575;
      11: atan_q30 = 34'sd524287;
      12: atan_q30 = 34'sd262143;
      13: atan_q30 = 34'sd131071;
      14: atan_q30 = 34'sd65535;
      15: atan_q30 = 34'sd32767;
      16: atan_q30 = 34'sd16383;
      17: atan_q30 = 34'sd8191;
      18: atan_q30 = 34'sd4095;
      19: atan_q30 = 34'sd2047;
      20: atan_q30 = 34'sd1023;
      21: atan_q30 = 34'sd511;
      22: atan_q30 = 34'sd255;
      23: atan_q30 = 34'sd127;
      24: atan_q30 = 34'sd63;
      25: atan_q30 = 34'sd31;
      26: atan_q30 = 34'sd15;
      27: atan_q30 = 34'sd7;
      28: atan_q30 = 34'sd3;
      29: atan_q30 = 34'sd1;
      default: atan_q30 = '0;
    endcase
  endfunction

  // round a Q30 x Q30 product back to Q30 (add half, floor shift)
  function automatic q30_t rnd_q30(input logic signed [2*QW-1:0] p);
    logic signed [2*QW-1:0] t;
    t = (p + (68'sd1 <<< 29)) >>> 30;
    rnd_q30 = t[QW-1:0];
  endfunction
endpackage
`default_nettype wire

>>> src/exyz_cordic.sv
// ---------------------------------------------------------------------------
// exyz_cordic
// Pipelined rotation-mode CORDIC, one register stage per micro-rotation.
// ---------------------------------------------------------------------------
`default_nettype none
module exyz_cordic #(
  parameter int ANGLE_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  input  wire  signed [ANGLE_BITS-1:0] angle,
  output logic                         out_valid,
  output exyz_pkg::q30_t               sin_q,
  output exyz_pkg::q30_t               cos_q
);
  import exyz_pkg::*;

  q30_t x   [CORDIC_STEPS+1];
  q30_t y   [CORDIC_STEPS+1];
  q30_t z   [CORDIC_STEPS+1];
  logic neg [CORDIC_STEPS+1];
  logic vld [CORDIC_STEPS+1];

  q30_t a_q30;
  assign a_q30 = q30_t'(angle) <<< (33 - ANGLE_BITS);

  // range reduction stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    x[0] <= Q30_ONE_OVER_K;
    y[0] <= '0;
    if (a_q30 > Q30_HALF_PI) begin
      z[0] <= a_q30 - Q30_PI;  neg[0] <= 1'b1;
    end else if (a_q30 < -Q30_HALF_PI) begin
      z[0] <= a_q30 + Q30_PI;  neg[0] <= 1'b1;
    end else begin
      z[0] <= a_q30;           neg[0] <= 1'b0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam int K = i % 32;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      neg[i+1] <= neg[i];
      if (z[i] >= 0) begin
        x[i+1] <= x[i] - (y[i] >>> K);
        y[i+1] <= y[i] + (x[i] >>> K);
        z[i+1] <= z[i] - atan_q30(K);
      end else begin
        x[i+1] <= x[i] + (y[i] >>> K);
        y[i+1] <= y[i] - (x[i] >>> K);
        z[i+1] <= z[i] + atan_q30(K);
      end
    end
  end

  assign out_valid = vld[CORDIC_STEPS];
  assign cos_q = neg[CORDIC_STEPS] ? -x[CORDIC_STEPS] : x[CORDIC_STEPS];
  assign sin_q = neg[CORDIC_STEPS] ? -y[CORDIC_STEPS] : y[CORDIC_STEPS];
endmodule
`default_nettype wire

>>> src/exyz_matrix.sv
// ---------------------------------------------------------------------------
// exyz_matrix
// Product stages: pair products, triple products, sums and element rounding.
// ---------------------------------------------------------------------------
`default_nettype none
module exyz_matrix #(
  parameter int ELEMENT_FRAC_BITS = 14
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 in_valid,
  input  exyz_pkg::q30_t                      sx, cx, sy, cy, sz, cz,
  output logic                                out_valid,
  output logic signed [exyz_pkg::IO_W-1:0]    el [9]
);
  import exyz_pkg::*;

  localparam int SH = 30 - ELEMENT_FRAC_BITS;
  localparam logic signed [QW-1:0] ONE = QW'(1) <<< ELEMENT_FRAC_BITS;

  function automatic logic signed [IO_W-1:0] to_el(input q30_t v);
    q30_t r;
    if (SH > 0) r = (v + (q30_t'(1) <<< (SH - 1))) >>> SH;
    else        r = v;
    if (r > ONE)  r = ONE;
    if (r < -ONE) r = -ONE;
    to_el = r[IO_W-1:0];
  endfunction

  // full signed product, then round back to Q30
  function automatic q30_t m(input q30_t a, input q30_t b);
    m = rnd_q30($signed({{QW{a[QW-1]}}, a}) * $signed({{QW{b[QW-1]}}, b}));
  endfunction

  // stage 1: pair products
  logic v1, v2, v3;
  q30_t sxsy, cxsy, cycz, cysz, sxcy, cxcy, cxsz, cxcz, sxsz, sxcz, sy1, sz1, cz1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0; else v1 <= in_valid;
    sxsy <= m(sx, sy);  cxsy <= m(cx, sy);
    cycz <= m(cy, cz);  cysz <= m(cy, sz);
    sxcy <= m(sx, cy);  cxcy <= m(cx, cy);
    cxsz <= m(cx, sz);  cxcz <= m(cx, cz);
    sxsz <= m(sx, sz);  sxcz <= m(sx, cz);
    sy1 <= sy;  sz1 <= sz;  cz1 <= cz;
  end

  // stage 2: triple products
  q30_t t10, t11, t20, t21;
  q30_t p00, p01, p02, p12, p22, a10, a11, a20, a21;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0; else v2 <= v1;
    t10 <= m(sxsy, cz1);  t11 <= m(sxsy, sz1);
    t20 <= m(cxsy, cz1);  t21 <= m(cxsy, sz1);
    p00 <= cycz;  p01 <= -cysz;  p02 <= sy1;  p12 <= -sxcy;  p22 <= cxcy;
    a10 <= cxsz;  a11 <= cxcz;   a20 <= sxsz; a21 <= sxcz;
  end

  // stage 3: sums, rounding and saturation
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0; else v3 <= v2;
    el[0] <= to_el(p00);
    el[1] <= to_el(p01);
    el[2] <= to_el(p02);
    el[3] <= to_el(t10 + a10);
    el[4] <= to_el(a11 - t11);
    el[5] <= to_el(p12);
    el[6] <= to_el(a20 - t20);
    el[7] <= to_el(t21 + a21);
    el[8] <= to_el(p22);
  end
  assign out_valid = v3;
endmodule
`default_nettype wire

>>> src/euler_xyz_rotation_matrix.sv
// ---------------------------------------------------------------------------
// euler_xyz_rotation_matrix
// Euler x-y-z angles (Q3.13 rad) to the 3x3 rotation matrix in Q1.14.
// ---------------------------------------------------------------------------
// Usage:
//   Drive angle_x/y/z and raise start; the transfer happens on any edge with
//   start high (busy is always low, the pipeline never stalls).
//   One item per cycle is accepted.
//   Pipeline: one range-reduction stage, one stage per CORDIC micro-rotation,
//   then three stages of products, triple products and rounding.
//   done is high for exactly one cycle per item with r00..r22 valid; the
//   receiver cannot hold results off and must take them then.
//   Reset (rst, synchronous) clears all valid bits; items in flight are
//   dropped. Throughput: 1 item per cycle, set by the fully unrolled CORDIC.
// ---------------------------------------------------------------------------
`default_nettype none
module euler_xyz_rotation_matrix #(
  parameter int ANGLE_BITS        = exyz_pkg::ANGLE_BITS_DEF,
  parameter int ELEMENT_FRAC_BITS = exyz_pkg::ELEM_FRAC_DEF,
  parameter int CORDIC_STEPS      = exyz_pkg::CORDIC_STEPS_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                start,
  output logic                               busy,
  input  wire  signed [exyz_pkg::IO_W-1:0]   angle_x,
  input  wire  signed [exyz_pkg::IO_W-1:0]   angle_y,
  input  wire  signed [exyz_pkg::IO_W-1:0]   angle_z,
  output logic                               done,
  output logic signed [exyz_pkg::IO_W-1:0]   r00, r01, r02,
  output logic signed [exyz_pkg::IO_W-1:0]   r10, r11, r12,
  output logic signed [exyz_pkg::IO_W-1:0]   r20, r21, r22
);
  import exyz_pkg::*;

  logic vx, vy, vz;
  q30_t sx, cx, sy, cy, sz, cz;
  logic signed [IO_W-1:0] el [9];

  assign busy = 1'b0;

  exyz_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cx (
    .clk, .rst, .in_valid(start), .angle(angle_x[ANGLE_BITS-1:0]),
    .out_valid(vx), .sin_q(sx), .cos_q(cx));
  exyz_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cy (
    .clk, .rst, .in_valid(start), .angle(angle_y[ANGLE_BITS-1:0]),
    .out_valid(vy), .sin_q(sy), .cos_q(cy));
  exyz_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cz (
    .clk, .rst, .in_valid(start), .angle(angle_z[ANGLE_BITS-1:0]),
    .out_valid(vz), .sin_q(sz), .cos_q(cz));

  exyz_matrix #(.ELEMENT_FRAC_BITS(ELEMENT_FRAC_BITS)) u_mat (
    .clk, .rst, .in_valid(vx & vy & vz),
    .sx, .cx, .sy, .cy, .sz, .cz,
    .out_valid(done), .el);

  assign r00 = el[0];  assign r01 = el[1];  assign r02 = el[2];
  assign r10 = el[3];  assign r11 = el[4];  assign r12 = el[5];
  assign r20 = el[6];  assign r21 = el[7];  assign r22 = el[8];
endmodule
`default_nettype wire

>>> src/exyz_checker.sv
// ---------------------------------------------------------------------------
// exyz_checker
// Port-level checks on the rotation matrix block.
// ---------------------------------------------------------------------------
`default_nettype none
module exyz_checker #(
  parameter int LAT = exyz_pkg::CORDIC_STEPS_DEF + 4
) (
  input wire clk,
  input wire rst,
  input wire start,
  input wire busy,
  input wire done,
  input wire signed [15:0] r00,
  input wire signed [15:0] r02,
  input wire signed [15:0] r22
);
  a_never_busy: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy raised");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT done)
    else $error("result missing after start");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without item");
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (r00 <= 16'sd16384 && r00 >= -16'sd16384 &&
              r02 <= 16'sd16384 && r02 >= -16'sd16384 &&
              r22 <= 16'sd16384 && r22 >= -16'sd16384))
    else $error("element out of range");
endmodule

bind euler_xyz_rotation_matrix exyz_checker #(.LAT(CORDIC_STEPS + 4)) u_chk (
  .clk, .rst, .start, .busy, .done, .r00, .r02, .r22);
`default_nettype wire

>>> bench/tb_euler_xyz_rotation_matrix.sv
// ---------------------------------------------------------------------------
// tb_euler_xyz_rotation_matrix
// Drives angle triples through the pose converter, predicts each matrix with
// a bit-exact CORDIC and product model, and checks the nine elements in order.
// ---------------------------------------------------------------------------
module tb_euler_xyz_rotation_matrix;
  timeunit 1ns;
  timeprecision 1ps;
  import exyz_pkg::*;

  localparam int FRAC      = ELEM_FRAC_DEF;
  localparam int STEPS     = CORDIC_STEPS_DEF;
  localparam int LATENCY   = STEPS + 4;
  localparam int WDOG_MAX  = 2000;
  localparam int N_RANDOM  = 800;

  typedef logic signed [IO_W-1:0] elem_t;
  typedef struct packed {
    elem_t a00, a01, a02, a10, a11, a12, a20, a21, a22;
  } matrix_t;
  typedef struct {
    logic signed [IO_W-1:0] ax, ay, az;
    logic                   has_exp;
    matrix_t                exp_m;
  } vec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic signed [IO_W-1:0] angle_x = '0, angle_y = '0, angle_z = '0;
  elem_t r00, r01, r02, r10, r11, r12, r20, r21, r22;

  matrix_t pending_matrices[$];
  int      mismatches = 0;
  int      idle_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  euler_xyz_rotation_matrix DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
    .done(done),
    .r00(r00), .r01(r01), .r02(r02),
    .r10(r10), .r11(r11), .r12(r12),
    .r20(r20), .r21(r21), .r22(r22)
  );

  // ---- predictor ----------------------------------------------------------
  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return fshift(a * b + (64'sd1 <<< 29), 30);
  endfunction

  function automatic void sin_cos(input logic signed [IO_W-1:0] ang,
                                  output longint s, output longint c);
    longint x, y, z, dx, dy;
    logic   flip;
    x = 652032874;
    y = 0;
    z = longint'(ang) * (64'sd1 <<< (33 - ANGLE_BITS_DEF));
    flip = 1'b0;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426;
      flip = 1'b1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426;
      flip = 1'b1;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_q30(i));
      end else begin
        x += dx; y -= dy; z += longint'(atan_q30(i));
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endfunction

  function automatic elem_t to_elem(longint v);
    longint one, t;
    one = 64'sd1 <<< FRAC;
    t = fshift(v + (64'sd1 <<< (29 - FRAC)), 30 - FRAC);
    if (t > one) t = one;
    if (t < -one) t = -one;
    return elem_t'(t);
  endfunction

  function automatic matrix_t rotation_matrix(logic signed [IO_W-1:0] ax,
                                              logic signed [IO_W-1:0] ay,
                                              logic signed [IO_W-1:0] az);
    longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
    matrix_t m;
    sin_cos(ax, sx, cx);
    sin_cos(ay, sy, cy);
    sin_cos(az, sz, cz);
    sxsy = qmul(sx, sy);
    cxsy = qmul(cx, sy);
    m.a00 = to_elem(qmul(cy, cz));
    m.a01 = to_elem(-qmul(cy, sz));
    m.a02 = to_elem(sy);
    m.a10 = to_elem(qmul(sxsy, cz) + qmul(cx, sz));
    m.a11 = to_elem(-qmul(sxsy, sz) + qmul(cx, cz));
    m.a12 = to_elem(-qmul(sx, cy));
    m.a20 = to_elem(-qmul(cxsy, cz) + qmul(sx, sz));
    m.a21 = to_elem(qmul(cxsy, sz) + qmul(sx, cz));
    m.a22 = to_elem(qmul(cx, cy));
    return m;
  endfunction

  // ---- result checker -----------------------------------------------------
  always @(posedge clk) begin
    matrix_t got, want;
    if (!rst && done) begin
      got = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
      if (pending_matrices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_matrices.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("matrix mismatch: expected %h actual %h", want, got);
        end
      end
    end
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---- stimulus -----------------------------------------------------------
  localparam elem_t ONE = elem_t'(1 << FRAC);
  localparam logic signed [IO_W-1:0] AMAX = 16'sh7fff;
  localparam logic signed [IO_W-1:0] AMIN = 16'sh8000;

  vec_t directed[$];

  // send one triple; gap_pct = chance of an idle cycle before it
  task automatic send(logic signed [IO_W-1:0] ax, logic signed [IO_W-1:0] ay,
                      logic signed [IO_W-1:0] az, int gap_pct);
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    angle_x <= ax;
    angle_y <= ay;
    angle_z <= az;
    pending_matrices.push_back(rotation_matrix(ax, ay, az));
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [IO_W-1:0] rand_angle();
    case ($urandom_range(5))
      0: return AMIN + 16'($urandom_range(3));
      1: return AMAX - 16'($urandom_range(3));
      // around +-pi/2 where range reduction kicks in
      2: return (($urandom_range(1) ? 16'sd12868 : -16'sd12868)
                 + $signed(16'($urandom_range(8)) - 16'sd4));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic signed [IO_W-1:0] b[6];
    int gaps[4];
    // identity rows: exact result typed in
    directed.push_back('{16'sd0, 16'sd0, 16'sd0, 1'b1,
                         '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}});
    b = '{AMIN, AMAX, 16'sd0, 16'sd12868, -16'sd12868, 16'sd25736};
    foreach (b[i])
      directed.push_back('{b[i], 16'sd0, 16'sd0, 1'b0, '0});
    foreach (b[i])
      directed.push_back('{16'sd0, b[i], 16'sd0, 1'b0, '0});
    foreach (b[i])
      directed.push_back('{16'sd0, 16'sd0, b[i], 1'b0, '0});
    directed.push_back('{AMAX, AMAX, AMAX, 1'b0, '0});
    directed.push_back('{AMIN, AMIN, AMIN, 1'b0, '0});
    directed.push_back('{16'sd12868, 16'sd12868, 16'sd12868, 1'b0, '0});
    directed.push_back('{-16'sd1, 16'sd1, -16'sd1, 1'b0, '0});

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      send(directed[i].ax, directed[i].ay, directed[i].az, 0);
      if (directed[i].has_exp) begin
        if (pending_matrices[pending_matrices.size()-1] !== directed[i].exp_m) begin
          mismatches++;
          if (mismatches <= 10)
            $display("predictor disagrees on row %0d: expected %h", i, directed[i].exp_m);
        end
      end
    end

    // hold off until the pipeline drains
    start <= 1'b0;
    while (pending_matrices.size() != 0) @(negedge clk);

    gaps = '{0, 49, 0, 11};
    for (int p = 0; p < 4; p++) begin
      for (int n = 0; n < N_RANDOM / 4; n++) begin
        if ($urandom_range(15) == 0)
          repeat ($urandom_range(3)) begin
            start <= 1'b0;
            @(negedge clk);
          end
        send(rand_angle(), rand_angle(), rand_angle(), gaps[p]);
      end
    end
    start <= 1'b0;

    while (pending_matrices.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
    if (mismatches == 0 && pending_matrices.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
